[rtl/windowed_leg_reassembly_receiver_defines.svh]
// Assertion macros for the leg reassembly receiver checker.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef WINDOWED_LEG_REASSEMBLY_RECEIVER_DEFINES_SVH
`define WINDOWED_LEG_REASSEMBLY_RECEIVER_DEFINES_SVH

// same-cycle implication
`define WLR_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define WLR_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[rtl/wlr_pkg.sv]
// Shared types, constants and helpers for the leg reassembly receiver.
// No dependencies.
package wlr_pkg;

    localparam int LEGS      = 8;
    localparam int LEG_BYTES = 32;
    localparam int SLOT_W    = $clog2(LEGS);
    localparam int SEQ_W     = SLOT_W + 1;
    localparam int OFF_W     = $clog2(LEG_BYTES + 1);
    localparam int ADDR_W    = $clog2(LEGS * LEG_BYTES);
    localparam int COUNT_W   = $clog2(LEGS + 1);
    localparam int WORD_W    = 64;
    localparam int BLEN_W    = 9;
    localparam int LANES     = WORD_W / 8;
    localparam int LANE_W    = $clog2(LANES);
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_datagram;
        logic       last_of_datagram;
    } wlr_in_t;

    typedef struct packed {
        logic              kind;
        logic [SEQ_W-1:0]  ack_seq;
        logic [WORD_W-1:0] block_word;
        logic [BLEN_W-1:0] block_length;
        logic              last_word;
    } wlr_out_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_NEW,
        ACC_DUP
    } wlr_acc_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FETCH,
        B_DRAIN,
        B_PUT
    } wlr_bstate_t;

    typedef enum logic {
        KIND_ACK   = 1'b0,
        KIND_BLOCK = 1'b1
    } wlr_kind_t;

    // one queued job: an ack, optionally followed by a block dump
    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic             blk;
        logic [OFF_W-1:0] len;
    } wlr_cmd_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } wlr_wr_t;

    typedef logic [LEGS-1:0][OFF_W-1:0] wlr_lens_t;

    function automatic logic [ADDR_W-1:0] leg_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [OFF_W-1:0]  off);
        return ADDR_W'(slot) * ADDR_W'(LEG_BYTES) + ADDR_W'(off);
    endfunction

endpackage

[rtl/wlr_queue.sv]
// Two-entry job queue between the classifier front and the result back end.
// Depends on wlr_pkg.
module wlr_queue
    import wlr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  wlr_cmd_t push_cmd,
    input  logic     pop,
    output wlr_cmd_t pop_cmd,
    output logic     full,
    output logic     empty
);

    wlr_cmd_t            entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/wlr_front.sv]
// Front end: takes link words, tracks the window and the open datagram,
// writes payload into leg storage and queues ack/block jobs. Depends on wlr_pkg.
module wlr_front
    import wlr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      link_valid,
    output logic      link_ready,
    input  wlr_in_t   link_word,
    input  logic      q_full,
    output logic      push,
    output wlr_cmd_t  push_cmd,
    output wlr_wr_t   wr,
    output wlr_lens_t lens,
    input  logic      blk_done
);

    logic                phase_reg, phase_next;
    logic [LEGS-1:0]     seen_reg, seen_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    wlr_lens_t           lens_reg, lens_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    wlr_acc_t            acc_reg, acc_next;
    logic [OFF_W-1:0]    off_reg, off_next;
    logic                wait_reg, wait_next;
    logic                accept;

    // held off while a block drains out of leg storage or the job queue is full
    assign link_ready = !q_full && !wait_reg;
    assign accept     = link_valid && link_ready;
    assign lens       = lens_reg;

    always_comb
    begin
        phase_next = phase_reg;
        seen_next  = seen_reg;
        count_next = count_reg;
        lens_next  = lens_reg;
        slot_next  = slot_reg;
        acc_next   = acc_reg;
        off_next   = off_reg;
        wait_next  = wait_reg;
        push       = 1'b0;
        push_cmd   = '0;
        wr         = '0;

        if (blk_done)
        begin
            lens_next = '0;
            wait_next = 1'b0;
        end

        if (accept)
        begin
            if (link_word.first_of_datagram)
            begin
                acc_next = ACC_NONE;
                off_next = '0;
                if ((link_word.data_byte >> SEQ_W) == '0 &&
                    link_word.data_byte[SEQ_W-1] == phase_reg)
                begin
                    slot_next = link_word.data_byte[SLOT_W-1:0];
                    acc_next  = seen_reg[slot_next] ? ACC_DUP : ACC_NEW;
                end
            end
            else if (acc_reg == ACC_NEW && off_reg < OFF_W'(LEG_BYTES))
            begin
                wr.en    = 1'b1;
                wr.addr  = leg_addr(slot_reg, off_reg);
                wr.data  = link_word.data_byte;
                off_next = off_reg + 1'b1;
            end

            if (link_word.last_of_datagram && acc_next != ACC_NONE)
            begin
                push         = 1'b1;
                push_cmd.seq = {phase_reg, slot_next};
                push_cmd.blk = 1'b0;
                push_cmd.len = off_next;
                if (acc_next == ACC_NEW)
                begin
                    seen_next[slot_next] = 1'b1;
                    count_next           = count_reg + 1'b1;
                    lens_next[slot_next] = off_next;
                    if (count_reg == COUNT_W'(LEGS - 1))
                    begin
                        // window complete: flip now, lengths stay until dump ends
                        push_cmd.blk = 1'b1;
                        phase_next   = ~phase_reg;
                        seen_next    = '0;
                        count_next   = '0;
                        if (off_next == '0)
                        begin
                            lens_next = '0;
                        end
                        else
                        begin
                            wait_next = 1'b1;
                        end
                    end
                end
                acc_next = ACC_NONE;
                off_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            seen_reg  <= '0;
            count_reg <= '0;
            lens_reg  <= '0;
            slot_reg  <= '0;
            acc_reg   <= ACC_NONE;
            off_reg   <= '0;
            wait_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            seen_reg  <= seen_next;
            count_reg <= count_next;
            lens_reg  <= lens_next;
            slot_reg  <= slot_next;
            acc_reg   <= acc_next;
            off_reg   <= off_next;
            wait_reg  <= wait_next;
        end
    end

endmodule

[rtl/wlr_back.sv]
// Back end: owns leg storage, emits acks and walks the block byte by byte
// into 64-bit words behind an output register. Depends on wlr_pkg.
module wlr_back
    import wlr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  wlr_wr_t   wr,
    input  wlr_lens_t lens,
    input  logic      q_empty,
    input  wlr_cmd_t  q_cmd,
    output logic      pop,
    output logic      blk_done,
    output logic      res_valid,
    input  logic      res_ready,
    output wlr_out_t  res_word
);

    logic [7:0]          mem [LEGS * LEG_BYTES];
    logic [7:0]          mem_q_reg;

    wlr_bstate_t         state_reg, state_next;
    logic [OFF_W-1:0]    len_reg;
    logic [OFF_W-1:0]    word_cnt_reg;
    logic [SLOT_W-1:0]   leg_reg;
    logic [OFF_W-1:0]    boff_reg;
    logic [LANE_W-1:0]   lane_reg;
    logic                rd_pend_reg;
    logic [LANE_W-1:0]   rd_lane_reg;
    logic                rd_zero_reg;
    logic [WORD_W-1:0]   word_reg;
    logic                out_valid_reg;
    wlr_out_t            out_reg;

    logic                slot_free;
    logic                rd_en;
    logic                load_ack;
    logic                load_word;
    logic                last_blk_word;
    logic                has_block;

    assign slot_free     = !out_valid_reg || res_ready;
    assign last_blk_word = (word_cnt_reg + OFF_W'(1)) == len_reg;
    assign has_block     = q_cmd.blk && q_cmd.len != '0;
    assign res_valid     = out_valid_reg;
    assign res_word      = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty && slot_free && has_block)
                begin
                    state_next = B_FETCH;
                end
            end
            B_FETCH:
            begin
                if (lane_reg == LANE_W'(LANES - 1))
                begin
                    state_next = B_DRAIN;
                end
            end
            B_DRAIN:
            begin
                state_next = B_PUT;
            end
            B_PUT:
            begin
                if (slot_free)
                begin
                    state_next = last_blk_word ? B_IDLE : B_FETCH;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // controls
    always_comb
    begin
        pop       = 1'b0;
        load_ack  = 1'b0;
        rd_en     = 1'b0;
        load_word = 1'b0;
        blk_done  = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                pop      = !q_empty && slot_free;
                load_ack = pop;
            end
            B_FETCH:
            begin
                rd_en = 1'b1;
            end
            B_DRAIN:
            begin
                rd_en = 1'b0;
            end
            B_PUT:
            begin
                load_word = slot_free;
                blk_done  = slot_free && last_blk_word;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[leg_addr(leg_reg, boff_reg)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_en;
            if (load_ack || load_word)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            len_reg      <= q_cmd.len;
            word_cnt_reg <= '0;
            leg_reg      <= '0;
            boff_reg     <= '0;
            lane_reg     <= '0;
        end
        if (rd_en)
        begin
            rd_lane_reg <= lane_reg;
            rd_zero_reg <= boff_reg >= lens[leg_reg];
            lane_reg    <= lane_reg + 1'b1;
            // offsets wrap at the completing leg length, stepping to the next leg
            if ((boff_reg + OFF_W'(1)) == len_reg)
            begin
                boff_reg <= '0;
                leg_reg  <= leg_reg + 1'b1;
            end
            else
            begin
                boff_reg <= boff_reg + 1'b1;
            end
        end
        if (rd_pend_reg)
        begin
            word_reg[rd_lane_reg * 8 +: 8] <= rd_zero_reg ? 8'h00 : mem_q_reg;
        end
        if (load_word)
        begin
            word_cnt_reg <= word_cnt_reg + 1'b1;
        end

        if (load_ack)
        begin
            out_reg.kind         <= KIND_ACK;
            out_reg.ack_seq      <= q_cmd.seq;
            out_reg.block_word   <= '0;
            out_reg.block_length <= '0;
            out_reg.last_word    <= !has_block;
        end
        else if (load_word)
        begin
            out_reg.kind         <= KIND_BLOCK;
            out_reg.ack_seq      <= '0;
            out_reg.block_word   <= word_reg;
            out_reg.block_length <= BLEN_W'(len_reg) * BLEN_W'(LEGS);
            out_reg.last_word    <= last_blk_word;
        end
    end

endmodule

[rtl/windowed_leg_reassembly_receiver.sv]
// Windowed leg reassembly receiver, top level.
// Depends on wlr_pkg, wlr_queue, wlr_front, wlr_back.
//
// link channel: one datagram byte per word, with first/last marks; the first
// byte is the sequence number, accepted only inside the current window of 8.
// res channel: acks (kind 0) and assembled block words (kind 1); last_word
// marks the final result caused by one link word.
// Throughput: one link word per cycle while no block is being dumped and the job queue is not full.
// An ack passes through the job queue and is loaded into the output register
// once the back end is idle and the output register is free.
// When the eighth leg completes and holds data, the link stalls until the last block word
// is loaded into the output register. Each 64-bit word is built from one storage read
// per byte lane, then a read drain and an output load; stalls on the result side
// lengthen the hold.
// A two-entry job queue between front and back lets acks back up while the
// result side stalls; with the queue full the link is held off.
// A stalled result holds its value in the output register.
// Reset clears window, seen marks, lengths and queue; leg storage needs no
// clearing pass since bytes past a leg's recorded length are output as zero.
module windowed_leg_reassembly_receiver
    import wlr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     link_valid,
    output logic     link_ready,
    input  wlr_in_t  link_word,
    output logic     res_valid,
    input  logic     res_ready,
    output wlr_out_t res_word
);

    logic      q_full;
    logic      q_empty;
    logic      push;
    logic      pop;
    wlr_cmd_t  push_cmd;
    wlr_cmd_t  pop_cmd;
    wlr_wr_t   wr;
    wlr_lens_t lens;
    logic      blk_done;

    wlr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .link_valid (link_valid),
        .link_ready (link_ready),
        .link_word  (link_word),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd),
        .wr         (wr),
        .lens       (lens),
        .blk_done   (blk_done)
    );

    wlr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    wlr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .lens      (lens),
        .q_empty   (q_empty),
        .q_cmd     (pop_cmd),
        .pop       (pop),
        .blk_done  (blk_done),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word)
    );

endmodule

[rtl/wlr_checker.sv]
// Port-level checks for the leg reassembly receiver, bound to the top level.
// Depends on wlr_pkg and windowed_leg_reassembly_receiver_defines.svh.
`include "windowed_leg_reassembly_receiver_defines.svh"

module wlr_checker
    import wlr_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     link_ready,
    input logic     res_valid,
    input logic     res_ready,
    input wlr_out_t res_word
);

    `WLR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_word), "result word changed while stalled")

    `WLR_ASSERT_NOW(a_ack_clean, res_valid && res_word.kind == KIND_ACK, res_word.block_word == '0 && res_word.block_length == '0, "ack carries block fields")

    `WLR_ASSERT_NOW(a_blk_clean, res_valid && res_word.kind == KIND_BLOCK, res_word.ack_seq == '0 && res_word.block_length != '0, "block word malformed")

    // a pending non-final result means a block dump is under way
    `WLR_ASSERT_NOW(a_dump_stall, res_valid && !res_word.last_word, !link_ready, "link open during block dump")

endmodule

bind windowed_leg_reassembly_receiver wlr_checker u_wlr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .link_ready (link_ready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_word   (res_word)
);
